### sv/btkbb_pkg.sv
`timescale 1ns / 1ps
package btkbb_pkg;

    localparam int MAX_KEEP = 16;
    localparam int IDX_W    = $clog2(MAX_KEEP);
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);
    localparam int KEY_W    = 32;
    localparam int SIZE_W   = 16;
    localparam int TAG_W    = 32;
    localparam int KEEP_W   = 5;
    localparam int BUDGET_W = 20;
    localparam int IN_W     = 80;
    localparam int OUT_W    = 88;
    localparam int PADDR_W  = 3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    localparam logic REG_KEEP   = 1'b0;
    localparam logic REG_BUDGET = 1'b1;

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_BUDGET = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    typedef struct packed {
        logic             ins_en;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] rd_addr;
    } t_store_ctl;

endpackage

### sv/btkbb_store.sv
`timescale 1ns / 1ps
module btkbb_store (
    input  logic                  i_clk,
    input  btkbb_pkg::t_store_ctl i_ctl,
    input  btkbb_pkg::t_entry     i_new,
    output btkbb_pkg::t_entry     o_rd
);
    import btkbb_pkg::*;

    t_entry r_mem [MAX_KEEP];

    assign o_rd = r_mem[i_ctl.rd_addr];

    // sorted row, entries above the insert point move up by one
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_KEEP; i++) begin
            if (i_ctl.ins_en) begin
                if (i == int'(i_ctl.pos)) begin
                    r_mem[i] <= i_new;
                end else if (i > int'(i_ctl.pos) && i <= int'(i_ctl.count) && i > 0) begin
                    r_mem[i] <= r_mem[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

endmodule

### sv/bounded_top_k_with_byte_budget.sv
`timescale 1ns / 1ps
// bounded top-k store with a key byte budget
// input beats on s_axis: tuser is the command (insert or drain), tdata holds
// sort_key, key_size and tag. result beats leave on m_axis, tlast marks the
// final beat of each command. keep_count and key_byte_budget sit on the apb
// port at byte addresses 0 and 4; write them only while the block is idle.
// an insert gives one result beat. one key comparator first checks the worst
// entry, then walks the sorted entry row one entry per cycle up to the insert
// position (0 to 15); the entry then shifts into place and the result is
// registered. an ignored or refused insert skips the walk and the shift.
// a drain gives one beat per kept entry (one empty beat if none), the first
// registered after its input beat is taken, then one beat per cycle while
// m_axis_tready is high.
// s_axis_tready is high only while the sequencer is idle, so one command is
// worked on at a time. a stalled receiver holds the result register and the
// sequencer waits with it. reset empties the store and the byte count and
// sets keep_count to 16 and the budget to its maximum.
module bounded_top_k_with_byte_budget (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [btkbb_pkg::IN_W-1:0]       s_axis_tdata,  // sort_key, key_size, tag
    input  logic                             s_axis_tuser,  // command
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status, kept, entry_valid, out_key, out_size, out_tag, zero fill
    output logic [btkbb_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [btkbb_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import btkbb_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_RESP  = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [KEEP_W-1:0]   r_keep;
    logic [BUDGET_W-1:0] r_budget;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [BUDGET_W-1:0] r_bytes, n_bytes;
    logic [BUDGET_W-1:0] r_base, n_base;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_dn, n_dn;
    t_entry              r_item, n_item;
    logic                r_rstat, n_rstat;
    logic                r_rkept, n_rkept;
    logic                r_ovalid, n_ovalid;
    logic [OUT_W-1:0]    r_odata, n_odata;
    logic                r_olast, n_olast;

    logic [CNT_W-1:0]    keff;
    logic [CNT_W-1:0]    worst;
    logic                out_free;
    logic                key_le;
    logic [BUDGET_W:0]   sum_need;
    logic [BUDGET_W:0]   sum_room;
    t_store_ctl          ctl;
    t_entry              rd;
    logic                wr_en;

    btkbb_store u_store (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_new (r_item),
        .o_rd  (rd)
    );

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == REG_BUDGET) ? {{(32-BUDGET_W){1'b0}}, r_budget}
                                              : {{(32-KEEP_W){1'b0}}, r_keep};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep   <= KEEP_W'(MAX_KEEP);
            r_budget <= '1;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_KEEP:   r_keep   <= pwdata[KEEP_W-1:0];
                REG_BUDGET: r_budget <= pwdata[BUDGET_W-1:0];
                default:    r_keep   <= r_keep;
            endcase
        end
    end

    assign keff     = (CNT_W'(r_keep) > CNT_W'(MAX_KEEP)) ? CNT_W'(MAX_KEEP) : CNT_W'(r_keep);
    assign worst    = (r_count == '0) ? '0 : r_count - 1'b1;
    assign out_free = !r_ovalid || m_axis_tready;
    assign key_le   = rd.key <= r_item.key;

    always_comb begin
        ctl.ins_en  = (r_state == S_SHIFT);
        ctl.pos     = r_pos[IDX_W-1:0];
        ctl.count   = r_count;
        unique case (r_state)
            S_EVAL:  ctl.rd_addr = worst[IDX_W-1:0];
            S_DRAIN: ctl.rd_addr = r_pos[IDX_W-1:0];
            default: ctl.rd_addr = r_pos[IDX_W-1:0];
        endcase
    end

    always_comb begin
        sum_need = {1'b0, r_bytes} + (BUDGET_W+1)'(r_item.size);
        sum_room = {1'b0, r_budget};
        if (r_count >= keff) begin
            sum_room = {1'b0, r_budget} + (BUDGET_W+1)'(rd.size);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_bytes  = r_bytes;
        n_base   = r_base;
        n_pos    = r_pos;
        n_dn     = r_dn;
        n_item   = r_item;
        n_rstat  = r_rstat;
        n_rkept  = r_rkept;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        n_olast  = r_olast;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_item.key  = s_axis_tdata[KEY_W-1:0];
                    n_item.size = s_axis_tdata[KEY_W+SIZE_W-1:KEY_W];
                    n_item.tag  = s_axis_tdata[KEY_W+SIZE_W+TAG_W-1:KEY_W+SIZE_W];
                    n_pos       = '0;
                    if (s_axis_tuser == CMD_DRAIN) begin
                        n_dn    = (r_count < keff) ? r_count : keff;
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                n_rkept = 1'b0;
                n_state = S_RESP;
                if (keff == '0) begin
                    n_rstat = ST_OK;
                end else if (BUDGET_W'(r_item.size) > r_budget) begin
                    n_rstat = ST_BUDGET;
                end else if (r_count >= keff && key_le) begin
                    n_rstat = ST_OK;
                end else if (sum_need > sum_room) begin
                    n_rstat = ST_BUDGET;
                end else begin
                    n_state = S_SCAN;
                    if (r_count >= keff) begin
                        n_base  = (r_bytes >= BUDGET_W'(rd.size))
                                  ? r_bytes - BUDGET_W'(rd.size) : '0;
                        n_count = worst;
                    end else begin
                        n_base  = r_bytes;
                    end
                end
            end
            S_SCAN: begin
                if (r_pos < r_count && key_le) begin
                    n_pos = r_pos + 1'b1;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_count = r_count + 1'b1;
                n_bytes = r_base + BUDGET_W'(r_item.size);
                n_rstat = ST_OK;
                n_rkept = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {{(OUT_W-83){1'b0}}, 80'd0, 1'b0, r_rkept, r_rstat};
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (r_dn == '0) begin
                        n_odata = '0;
                        n_olast = 1'b1;
                    end else begin
                        n_odata = {{(OUT_W-83){1'b0}}, rd.tag, rd.size, rd.key,
                                   1'b1, 1'b0, 1'b0};
                        n_olast = (r_pos + 1'b1 == r_dn);
                        n_pos   = r_pos + 1'b1;
                    end
                    if (r_dn == '0 || r_pos + 1'b1 == r_dn) begin
                        n_count = '0;
                        n_bytes = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_bytes  <= '0;
            r_ovalid <= 1'b0;
            r_pos    <= '0;
            r_dn     <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_ovalid <= n_ovalid;
            r_pos    <= n_pos;
            r_dn     <= n_dn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_item  <= n_item;
        r_rstat <= n_rstat;
        r_rkept <= n_rkept;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEEP))
        else $error("entry count above store depth");

    a_shift_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the store");

    a_kept_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tlast && !m_axis_tdata[2])
        else $error("insert result not a single final beat");

endmodule
